// ----- hw/rtl/vsna_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package vsna_pkg;

  // wide width for block end arithmetic (address plus size plus merges)
  localparam int VW = 20;
  localparam int STEP_W = 23;
  localparam logic [STEP_W-1:0] WALK_LIMIT = 23'd4194304;
  localparam int LOG_DEPTH = 2048;
  localparam int LAW = 11;
  localparam logic [15:0] INIT_SIZE = 16'd1000;
  localparam logic [17:0] GROW_STEP = 18'd1000;
  localparam logic [17:0] GROW_FULL = 18'd1998;

  localparam logic [1:0] ST_ALLOC = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [5:0] {
    CMD_NONE, CMD_CLEAR, CMD_INIT_A, CMD_INIT_B, CMD_START, CMD_PASS,
    CMD_RD_P, CMD_SET_Q, CMD_RD_Q, CMD_ADD_Q, CMD_MSTEP, CMD_STEP,
    CMD_LD_NX_M, CMD_LD_NX_X, CMD_RD_NX1, CMD_W_INF_PV, CMD_RD_PV1, CMD_W_LNK_NX,
    CMD_W_INF_RP, CMD_RD_R, CMD_W_LNK_ZERO, CMD_RD_P1, CMD_W_INF_QP, CMD_NEXT_P,
    CMD_GROW, CMD_LD_LEFT, CMD_RD_LEFT1, CMD_W_LNK_TOP, CMD_RD_ROV1, CMD_W_INF_TOP,
    CMD_RD_TOP1, CMD_W_TOP1, CMD_RD_TOP, CMD_W_TOPW, CMD_RD_T, CMD_W_ZERO,
    CMD_RB_RD, CMD_RB_WR, CMD_DONE_ALLOC, CMD_DONE_PROBE, CMD_DONE_FAIL
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic link_empty;
    logic link_ne_p;
    logic link_eq_rover;
    logic step_over;
    logic r_gt;
    logic r_eq;
    logic probe;
    logic can_grow;
    logic log_empty;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/vsna_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vsna_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire vsna_pkg::dp_status_t st,
  output vsna_pkg::cmd_t           cmd,
  output logic                     busy
);

  typedef enum logic [5:0] {
    S_CLEAR, S_INIT_A, S_INIT_B, S_IDLE, S_PASS, S_RD_P, S_SET_Q, S_RD_Q, S_CHK_Q,
    S_OVER_M, S_RD_NX1, S_W_PV, S_RD_PV1, S_W_NX, S_RD_QA, S_ADD_Q, S_OVER_S,
    S_W_RP, S_RD_R, S_W_Z, S_DONE_A, S_CHK_X, S_W_QP, S_RD_P1, S_NEXT, S_END,
    S_DONE_P, S_LEFT, S_RD_L1, S_W_LT, S_RD_R1, S_W_IT, S_RD_T1, S_W_T1, S_RD_TP,
    S_W_TW, S_RD_T, S_W_ZW, S_RB_RD, S_RB_WR
  } state_t;

  state_t state, state_next;
  logic   exact, exact_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    exact_next = exact;
    cmd = vsna_pkg::CMD_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd = vsna_pkg::CMD_CLEAR;
        if (st.clear_last) state_next = S_INIT_A;
      end
      S_INIT_A: begin cmd = vsna_pkg::CMD_INIT_A; state_next = S_INIT_B; end
      S_INIT_B: begin cmd = vsna_pkg::CMD_INIT_B; state_next = S_IDLE; end
      S_IDLE: begin
        if (start) begin
          cmd = vsna_pkg::CMD_START;
          state_next = S_RD_P;
        end
      end
      S_PASS: begin cmd = vsna_pkg::CMD_PASS; state_next = S_RD_P; end
      S_RD_P: begin cmd = vsna_pkg::CMD_RD_P; state_next = S_SET_Q; end
      S_SET_Q: begin cmd = vsna_pkg::CMD_SET_Q; state_next = S_RD_Q; end
      S_RD_Q: begin cmd = vsna_pkg::CMD_RD_Q; state_next = S_CHK_Q; end
      S_CHK_Q: begin
        if (st.link_empty) begin
          cmd = vsna_pkg::CMD_MSTEP;
          state_next = S_OVER_M;
        end else begin
          cmd = vsna_pkg::CMD_STEP;
          state_next = S_OVER_S;
        end
      end
      S_OVER_M: begin
        if (st.step_over) begin
          state_next = S_RB_RD;
        end else begin
          cmd = vsna_pkg::CMD_LD_NX_M;
          exact_next = 1'b0;
          state_next = S_RD_NX1;
        end
      end
      S_RD_NX1: begin cmd = vsna_pkg::CMD_RD_NX1; state_next = S_W_PV; end
      S_W_PV: begin cmd = vsna_pkg::CMD_W_INF_PV; state_next = S_RD_PV1; end
      S_RD_PV1: begin cmd = vsna_pkg::CMD_RD_PV1; state_next = S_W_NX; end
      S_W_NX: begin
        cmd = vsna_pkg::CMD_W_LNK_NX;
        state_next = exact ? S_RD_R : S_RD_QA;
      end
      S_RD_QA: begin cmd = vsna_pkg::CMD_RD_Q; state_next = S_ADD_Q; end
      S_ADD_Q: begin cmd = vsna_pkg::CMD_ADD_Q; state_next = S_RD_Q; end
      S_OVER_S: begin
        if (st.step_over) begin
          state_next = S_RB_RD;
        end else if (!st.probe && st.r_gt) begin
          cmd = vsna_pkg::CMD_RD_P;
          state_next = S_W_RP;
        end else if (!st.probe && st.r_eq) begin
          cmd = vsna_pkg::CMD_RD_P1;
          state_next = S_CHK_X;
        end else begin
          cmd = vsna_pkg::CMD_RD_P;
          state_next = S_W_QP;
        end
      end
      S_W_RP: begin cmd = vsna_pkg::CMD_W_INF_RP; state_next = S_RD_R; end
      S_RD_R: begin cmd = vsna_pkg::CMD_RD_R; state_next = S_W_Z; end
      S_W_Z: begin cmd = vsna_pkg::CMD_W_LNK_ZERO; state_next = S_DONE_A; end
      S_DONE_A: begin cmd = vsna_pkg::CMD_DONE_ALLOC; state_next = S_IDLE; end
      S_CHK_X: begin
        // exact fit only when another block stays on the list
        if (st.link_ne_p) begin
          cmd = vsna_pkg::CMD_LD_NX_X;
          exact_next = 1'b1;
          state_next = S_RD_NX1;
        end else begin
          cmd = vsna_pkg::CMD_RD_P;
          state_next = S_W_QP;
        end
      end
      S_W_QP: begin cmd = vsna_pkg::CMD_W_INF_QP; state_next = S_RD_P1; end
      S_RD_P1: begin cmd = vsna_pkg::CMD_RD_P1; state_next = S_NEXT; end
      S_NEXT: begin
        cmd = vsna_pkg::CMD_NEXT_P;
        state_next = st.link_eq_rover ? S_END : S_RD_P;
      end
      S_END: begin
        if (st.probe) begin
          state_next = S_DONE_P;
        end else if (!st.can_grow) begin
          state_next = S_RB_RD;
        end else begin
          cmd = vsna_pkg::CMD_GROW;
          state_next = S_LEFT;
        end
      end
      S_DONE_P: begin cmd = vsna_pkg::CMD_DONE_PROBE; state_next = S_IDLE; end
      S_LEFT: begin cmd = vsna_pkg::CMD_LD_LEFT; state_next = S_RD_L1; end
      S_RD_L1: begin cmd = vsna_pkg::CMD_RD_LEFT1; state_next = S_W_LT; end
      S_W_LT: begin cmd = vsna_pkg::CMD_W_LNK_TOP; state_next = S_RD_R1; end
      S_RD_R1: begin cmd = vsna_pkg::CMD_RD_ROV1; state_next = S_W_IT; end
      S_W_IT: begin cmd = vsna_pkg::CMD_W_INF_TOP; state_next = S_RD_T1; end
      S_RD_T1: begin cmd = vsna_pkg::CMD_RD_TOP1; state_next = S_W_T1; end
      S_W_T1: begin cmd = vsna_pkg::CMD_W_TOP1; state_next = S_RD_TP; end
      S_RD_TP: begin cmd = vsna_pkg::CMD_RD_TOP; state_next = S_W_TW; end
      S_W_TW: begin cmd = vsna_pkg::CMD_W_TOPW; state_next = S_RD_T; end
      S_RD_T: begin cmd = vsna_pkg::CMD_RD_T; state_next = S_W_ZW; end
      S_W_ZW: begin cmd = vsna_pkg::CMD_W_ZERO; state_next = S_PASS; end
      S_RB_RD: begin
        // undo the request's writes, newest first
        if (st.log_empty) begin
          cmd = vsna_pkg::CMD_DONE_FAIL;
          state_next = S_IDLE;
        end else begin
          cmd = vsna_pkg::CMD_RB_RD;
          state_next = S_RB_WR;
        end
      end
      S_RB_WR: begin cmd = vsna_pkg::CMD_RB_WR; state_next = S_RB_RD; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      exact <= 1'b0;
    end else begin
      state <= state_next;
      exact <= exact_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/vsna_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vsna_datapath #(
  parameter int MEMORY_WORDS = 65536,
  parameter int EMPTY_MARKER = 65535,
  parameter int FIRST_FREE_START = 20
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire vsna_pkg::cmd_t cmd,
  input  wire logic [15:0]  request_size,
  input  wire logic         probe_only,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_wdata,
  output vsna_pkg::dp_status_t st,
  output logic              done,
  output logic [15:0]       node_address,
  output logic [1:0]        status
);

  localparam int AW = $clog2(MEMORY_WORDS);
  localparam int VW = vsna_pkg::VW;
  localparam int LAW = vsna_pkg::LAW;
  localparam logic [15:0] EMPTY = 16'(EMPTY_MARKER);
  localparam logic [15:0] FFS = 16'(FIRST_FREE_START);

  logic [31:0] mem [MEMORY_WORDS];
  logic [AW+31:0] log_mem [vsna_pkg::LOG_DEPTH];

  logic [31:0]    rdata;
  logic [AW+31:0] log_q;
  logic [AW-1:0]  last_addr, clr;
  logic [LAW:0]   logptr;
  logic [15:0]    p, rover, top, hi, nx, pv, left, t, s, keep_rover, keep_top;
  logic [VW-1:0]  q;
  logic           probe;
  logic [vsna_pkg::STEP_W-1:0] steps;

  logic           rd_en, we, logged;
  logic [VW-1:0]  raddr_w;
  logic [AW-1:0]  raddr, waddr;
  logic [31:0]    wdata;
  logic           log_push;
  logic signed [VW:0] r;
  logic [17:0]    diff, tw, t_next;
  logic [16:0]    top2;

  assign r = $signed({1'b0, q}) - $signed({{(VW-15){1'b0}}, s});
  assign diff = {2'b00, hi} - {2'b00, top};
  assign top2 = {1'b0, top} + 17'd2;

  always_comb begin
    if (diff >= vsna_pkg::GROW_FULL) tw = {2'b00, top} + vsna_pkg::GROW_STEP;
    else tw = {2'b00, top} + 18'd1 + {1'b0, diff[17:1]};
    t_next = (tw > {2'b00, EMPTY}) ? {2'b00, EMPTY} : tw;
  end

  always_comb begin
    st.clear_last = (clr == {AW{1'b1}});
    st.link_empty = (rdata[15:0] == EMPTY);
    st.link_ne_p = (rdata[15:0] != p);
    st.link_eq_rover = (rdata[15:0] == rover);
    st.step_over = (steps > vsna_pkg::WALK_LIMIT);
    st.r_gt = (r > $signed({{(VW-16){1'b0}}, {1'b0, p} + 17'd1}));
    st.r_eq = (r == $signed({{(VW-15){1'b0}}, p}));
    st.probe = probe;
    st.can_grow = (top2 < {1'b0, hi}) && (top2 <= {1'b0, EMPTY});
    st.log_empty = (logptr == '0);
  end

  always_comb begin
    rd_en = 1'b0;
    raddr_w = '0;
    we = 1'b0;
    logged = 1'b1;
    waddr = last_addr;
    wdata = rdata;
    case (cmd)
      vsna_pkg::CMD_CLEAR: begin we = 1'b1; logged = 1'b0; waddr = clr; wdata = '0; end
      vsna_pkg::CMD_INIT_A: begin
        we = 1'b1; logged = 1'b0; waddr = AW'(FIRST_FREE_START);
        wdata = {vsna_pkg::INIT_SIZE, EMPTY};
      end
      vsna_pkg::CMD_INIT_B: begin
        we = 1'b1; logged = 1'b0; waddr = AW'(FIRST_FREE_START + 1);
        wdata = {FFS, FFS};
      end
      vsna_pkg::CMD_RD_P: begin rd_en = 1'b1; raddr_w = VW'(p); end
      vsna_pkg::CMD_RD_Q: begin rd_en = 1'b1; raddr_w = q; end
      vsna_pkg::CMD_MSTEP: begin rd_en = 1'b1; raddr_w = q + VW'(1); end
      vsna_pkg::CMD_RD_NX1: begin rd_en = 1'b1; raddr_w = VW'(nx) + VW'(1); end
      vsna_pkg::CMD_RD_PV1: begin rd_en = 1'b1; raddr_w = VW'(pv) + VW'(1); end
      vsna_pkg::CMD_RD_R: begin rd_en = 1'b1; raddr_w = r[VW-1:0]; end
      vsna_pkg::CMD_RD_P1: begin rd_en = 1'b1; raddr_w = VW'(p) + VW'(1); end
      vsna_pkg::CMD_GROW: begin rd_en = 1'b1; raddr_w = VW'(rover) + VW'(1); end
      vsna_pkg::CMD_RD_LEFT1: begin rd_en = 1'b1; raddr_w = VW'(left) + VW'(1); end
      vsna_pkg::CMD_RD_ROV1: begin rd_en = 1'b1; raddr_w = VW'(rover) + VW'(1); end
      vsna_pkg::CMD_RD_TOP1: begin rd_en = 1'b1; raddr_w = VW'(top) + VW'(1); end
      vsna_pkg::CMD_RD_TOP: begin rd_en = 1'b1; raddr_w = VW'(top); end
      vsna_pkg::CMD_RD_T: begin rd_en = 1'b1; raddr_w = VW'(t); end
      vsna_pkg::CMD_W_INF_PV: begin we = 1'b1; wdata = {pv, rdata[15:0]}; end
      vsna_pkg::CMD_W_LNK_NX: begin we = 1'b1; wdata = {rdata[31:16], nx}; end
      vsna_pkg::CMD_W_INF_RP: begin
        we = 1'b1; wdata = {16'(r[15:0] - p), rdata[15:0]};
      end
      vsna_pkg::CMD_W_LNK_ZERO: begin we = 1'b1; wdata = {rdata[31:16], 16'h0000}; end
      vsna_pkg::CMD_W_INF_QP: begin
        we = 1'b1; wdata = {16'(q[15:0] - p), rdata[15:0]};
      end
      vsna_pkg::CMD_W_LNK_TOP: begin we = 1'b1; wdata = {rdata[31:16], top}; end
      vsna_pkg::CMD_W_INF_TOP: begin we = 1'b1; wdata = {top, rdata[15:0]}; end
      vsna_pkg::CMD_W_TOP1: begin we = 1'b1; wdata = {left, rover}; end
      vsna_pkg::CMD_W_TOPW: begin we = 1'b1; wdata = {16'(t - top), EMPTY}; end
      vsna_pkg::CMD_W_ZERO: begin we = 1'b1; wdata = '0; end
      vsna_pkg::CMD_RB_WR: begin
        we = 1'b1; logged = 1'b0; waddr = log_q[AW+31:32]; wdata = log_q[31:0];
      end
      default: ;
    endcase
    raddr = raddr_w[AW-1:0];
    // only real changes go to the undo log
    log_push = we && logged && (wdata != rdata);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
    if (log_push) log_mem[logptr[LAW-1:0]] <= {last_addr, rdata};
    if (cmd == vsna_pkg::CMD_RB_RD) log_q <= log_mem[logptr[LAW-1:0] - 1'b1];
  end

  always_ff @(posedge clk) begin
    if (rd_en) last_addr <= raddr;
    case (cmd)
      vsna_pkg::CMD_START: begin
        s <= request_size;
        probe <= probe_only;
        keep_rover <= rover;
        keep_top <= top;
        steps <= '0;
        p <= rover;
      end
      vsna_pkg::CMD_PASS: p <= rover;
      vsna_pkg::CMD_SET_Q: q <= VW'(p) + VW'(rdata[31:16]);
      vsna_pkg::CMD_ADD_Q: q <= q + VW'(rdata[31:16]);
      vsna_pkg::CMD_MSTEP, vsna_pkg::CMD_STEP: steps <= steps + 1'b1;
      vsna_pkg::CMD_LD_NX_M, vsna_pkg::CMD_LD_NX_X: begin
        nx <= rdata[15:0];
        pv <= rdata[31:16];
      end
      vsna_pkg::CMD_NEXT_P: p <= rdata[15:0];
      vsna_pkg::CMD_GROW: t <= t_next[15:0];
      vsna_pkg::CMD_LD_LEFT: left <= rdata[31:16];
      vsna_pkg::CMD_DONE_ALLOC: begin
        node_address <= r[15:0];
        status <= vsna_pkg::ST_ALLOC;
      end
      vsna_pkg::CMD_DONE_PROBE: begin
        node_address <= EMPTY;
        status <= vsna_pkg::ST_PROBE;
      end
      vsna_pkg::CMD_DONE_FAIL: begin
        node_address <= 16'h0000;
        status <= vsna_pkg::ST_OVERFLOW;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rover <= FFS;
      top <= 16'(FIRST_FREE_START + 1000);
      hi <= 16'hFFFF;
      clr <= '0;
      logptr <= '0;
      done <= 1'b0;
    end else begin
      done <= (cmd == vsna_pkg::CMD_DONE_ALLOC) || (cmd == vsna_pkg::CMD_DONE_PROBE) ||
              (cmd == vsna_pkg::CMD_DONE_FAIL);
      if (cfg_we) hi <= cfg_wdata;
      if (log_push) logptr <= logptr + 1'b1;
      case (cmd)
        vsna_pkg::CMD_CLEAR: clr <= clr + 1'b1;
        vsna_pkg::CMD_START: logptr <= '0;
        vsna_pkg::CMD_LD_NX_M: if (q == VW'(rover)) rover <= rdata[15:0];
        vsna_pkg::CMD_LD_NX_X: rover <= rdata[15:0];
        vsna_pkg::CMD_W_INF_RP: rover <= p;
        vsna_pkg::CMD_W_ZERO: begin
          top <= t;
          rover <= top;
        end
        vsna_pkg::CMD_RB_RD: logptr <= logptr - 1'b1;
        vsna_pkg::CMD_DONE_FAIL: begin
          rover <= keep_rover;
          top <= keep_top;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/variable_size_node_allocator.sv -----
// walk: every free block visited and every merge is served in turn by the
// single read port of the word memory; growth adds its own writes and a new pass
// throughput: one request at a time, a new start is taken in the cycle that shows done
// overflow replays the undo log, a log read and then a memory write for each logged write
// reset: synchronous; a clearing pass over all MEMORY_WORDS words and the initial free list holds busy high
// results show for one cycle on done; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none
module variable_size_node_allocator #(
  parameter int MEMORY_WORDS = 65536,
  parameter int EMPTY_MARKER = 65535,
  parameter int FIRST_FREE_START = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] request_size,
  input  wire logic        probe_only,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output logic             done,
  output logic [15:0]      node_address,
  output logic [1:0]       status
);

  vsna_pkg::cmd_t       cmd;
  vsna_pkg::dp_status_t st;

  vsna_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  vsna_datapath #(
    .MEMORY_WORDS     (MEMORY_WORDS),
    .EMPTY_MARKER     (EMPTY_MARKER),
    .FIRST_FREE_START (FIRST_FREE_START)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .request_size (request_size),
    .probe_only   (probe_only),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .st           (st),
    .done         (done),
    .node_address (node_address),
    .status       (status)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/vsna_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vsna_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [15:0] node_address,
  input wire logic [1:0]  status
);

  // a result only ends a transfer that was in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without request in flight");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result held longer than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == vsna_pkg::ST_ALLOC || status == vsna_pkg::ST_PROBE ||
              status == vsna_pkg::ST_OVERFLOW))
    else $error("undefined status code");

  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == vsna_pkg::ST_OVERFLOW) |-> (node_address == 16'h0000))
    else $error("overflow with nonzero address");

endmodule

bind variable_size_node_allocator vsna_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .node_address (node_address),
  .status       (status)
);
`default_nettype wire

// ----- tb/sv/variable_size_node_allocator_test.sv -----
`timescale 1ns / 1ps
module variable_size_node_allocator_test;

  localparam int MEM_WORDS = 65536;
  localparam int EMPTY = 65535;
  localparam int FREE_START = 20;
  localparam longint STEP_CAP = 4194304;
  localparam int IDLE_LIMIT = 400000;

  typedef struct {
    logic [15:0] addr;
    logic [1:0] st;
  } alloc_result_t;

  typedef struct {
    int idx;
    logic [31:0] old;
  } undo_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [15:0] request_size = '0;
  logic probe_only = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic busy;
  logic done;
  logic [15:0] node_address;
  logic [1:0] status;

  logic [31:0] heap_mem [MEM_WORDS];
  int rover;
  int lower_top;
  int upper_low;
  undo_entry_t undo_log[$];
  alloc_result_t pending_results[$];
  int err_count = 0;
  int idle_cycles = 0;
  bit allow_gaps = 1'b1;

  variable_size_node_allocator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request_size(request_size), .probe_only(probe_only),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .node_address(node_address), .status(status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int widx(longint a);
    return int'(a & (MEM_WORDS - 1));
  endfunction

  function automatic longint link_of(longint a);
    return longint'(heap_mem[widx(a)][15:0]);
  endfunction

  function automatic longint info_of(longint a);
    return longint'(heap_mem[widx(a)][31:16]);
  endfunction

  task automatic put_link(longint a, longint v);
    int i;
    i = widx(a);
    undo_log.push_back('{i, heap_mem[i]});
    heap_mem[i][15:0] = v[15:0];
  endtask

  task automatic put_info(longint a, longint v);
    int i;
    i = widx(a);
    undo_log.push_back('{i, heap_mem[i]});
    heap_mem[i][31:16] = v[15:0];
  endtask

  task automatic heap_reset();
    for (int i = 0; i < MEM_WORDS; i++) heap_mem[i] = '0;
    heap_mem[FREE_START] = {16'd1000, 16'(EMPTY)};
    heap_mem[FREE_START + 1] = {16'(FREE_START), 16'(FREE_START)};
    rover = FREE_START;
    lower_top = FREE_START + 1000;
    upper_low = 65535;
  endtask

  // allocation walk; on overflow every write of this request is rolled back
  task automatic predict_alloc(input logic [15:0] sz_in, input bit probe,
                               output alloc_result_t res);
    longint s, p, q, r, nx, pv, steps, top, hi, t, left;
    int keep_rover, keep_top;
    bit failed;
    s = longint'(sz_in);
    keep_rover = rover;
    keep_top = lower_top;
    steps = 0;
    failed = 1'b0;
    undo_log.delete();
    forever begin
      p = rover;
      do begin
        q = p + info_of(p);
        while (link_of(q) == EMPTY && !failed) begin
          steps++;
          if (steps > STEP_CAP) begin
            failed = 1'b1;
          end else begin
            nx = link_of(q + 1);
            pv = info_of(q + 1);
            if (q == rover) rover = int'(nx);
            put_info(nx + 1, pv);
            put_link(pv + 1, nx);
            q += info_of(q);
          end
        end
        if (!failed) begin
          steps++;
          if (steps > STEP_CAP) failed = 1'b1;
        end
        if (failed) break;
        if (!probe) begin
          r = q - s;
          if (r > p + 1) begin
            put_info(p, r - p);
            rover = int'(p);
            put_link(r, 0);
            res = '{r[15:0], vsna_pkg::ST_ALLOC};
            return;
          end
          if (r == p && link_of(p + 1) != p) begin
            nx = link_of(p + 1);
            pv = info_of(p + 1);
            rover = int'(nx);
            put_info(nx + 1, pv);
            put_link(pv + 1, nx);
            put_link(r, 0);
            res = '{r[15:0], vsna_pkg::ST_ALLOC};
            return;
          end
        end
        put_info(p, q - p);
        p = link_of(p + 1);
      end while (p != rover);
      if (!failed && probe) begin
        res = '{16'(EMPTY), vsna_pkg::ST_PROBE};
        return;
      end
      top = lower_top;
      hi = upper_low;
      if (failed || !(top + 2 < hi && top + 2 <= EMPTY)) begin
        while (undo_log.size() > 0) begin
          undo_entry_t e;
          e = undo_log.pop_back();
          heap_mem[e.idx] = e.old;
        end
        rover = keep_rover;
        lower_top = keep_top;
        res = '{16'd0, vsna_pkg::ST_OVERFLOW};
        return;
      end
      if (hi - top >= 1998) t = top + 1000;
      else t = top + 1 + (hi - top) / 2;
      left = info_of(longint'(rover) + 1);
      q = top;
      put_link(left + 1, q);
      put_info(longint'(rover) + 1, q);
      if (t > EMPTY) t = EMPTY;
      put_link(q + 1, rover);
      put_info(q + 1, left);
      put_link(q, EMPTY);
      put_info(q, t - top);
      lower_top = int'(t);
      put_link(t, 0);
      put_info(t, 0);
      rover = int'(q);
    end
  endtask

  task automatic send_request(input logic [15:0] sz, input bit probe);
    alloc_result_t res;
    int gap;
    request_size <= sz;
    probe_only <= probe;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_alloc(sz, probe, res);
    pending_results.push_back(res);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_upper_low(input logic [15:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    upper_low = int'(v);
  endtask

  function automatic logic [15:0] random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return 16'($urandom_range(1, 32));
    if (pick < 97) return 16'($urandom_range(100, 2500));
    if (pick < 99) return 16'($urandom_range(0, 65535));
    return 16'(pick[0] ? 0 : 65535);
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) send_request(16'($urandom), 1'b1);
      else send_request(random_size(), 1'b0);
    end
  endtask

  task automatic test_directed();
    send_request(16'd1, 1'b0);
    send_request(16'hFFFF, 1'b1);
    send_request(16'd0, 1'b0);
    send_request(16'd0, 1'b1);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd500, 1'b0);
    send_request(16'd1200, 1'b0);
    send_request(16'd2, 1'b0);
    send_request(16'hAAAA, 1'b0);
    send_request(16'h5555, 1'b1);
  endtask

  task automatic test_upper_limit_zero();
    write_upper_low(16'd0);
    send_request(16'd3, 1'b0);
    send_request(16'd3000, 1'b0);
    send_request(16'd0, 1'b1);
    send_request(16'd7, 1'b0);
  endtask

  task automatic test_tight_growth();
    write_upper_low(16'(lower_top + $urandom_range(0, 3000)));
    run_random(300);
    write_upper_low(16'(lower_top + 3));
    send_request(16'd2000, 1'b0);
    send_request(16'd1, 1'b0);
  endtask

  task automatic test_random_default();
    write_upper_low(16'hFFFF);
    run_random(700);
  endtask

  task automatic test_random_no_gaps();
    write_upper_low(16'(lower_top + $urandom_range(1000, 20000)));
    allow_gaps = 1'b0;
    run_random(400);
    write_upper_low(16'hFFFF);
    run_random(100);
  endtask

  // result checker: done is a one-cycle strobe
  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result addr=%h status=%0d", $time, node_address, status);
        err_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (node_address !== exp_res.addr) begin
          $display("%0t: node_address expected %h actual %h", $time, exp_res.addr,
                   node_address);
          err_count++;
        end
        if (status !== exp_res.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.st, status);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    heap_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // clearing pass after reset
    while (busy) @(posedge clk);
    test_directed();
    test_upper_limit_zero();
    test_random_default();
    test_tight_growth();
    test_random_no_gaps();
    drain();
    repeat (100) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
